// ===== hdl/dfpwm_pkg.sv =====
package dfpwm_pkg;

    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 10;

    localparam logic [CfgIndexWidth-1:0] REG_LPF_COEFF = 8'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RAMP_STEP = 8'd1;

    localparam logic [8:0] LPF_COEFF_RESET = 9'd140;
    localparam logic [8:0] LPF_COEFF_MAX   = 9'd256;
    localparam logic [9:0] RAMP_STEP_RESET = 10'd1;

    localparam logic signed [8:0]  LEVEL_HIGH   = 9'sd127;
    localparam logic signed [8:0]  LEVEL_LOW    = -9'sd128;
    localparam logic signed [11:0] STRENGTH_MIN = 12'sd8;
    localparam logic signed [11:0] STRENGTH_MAX = 12'sd1023;
    localparam logic [9:0]         STRENGTH_TOP = 10'd1023;
    localparam logic signed [19:0] CHARGE_ROUND = 20'sd512;
    localparam logic signed [18:0] FILTER_ROUND = 19'sd128;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // accept a bit word, form the charge product
        logic update;  // charge, strength, polarity and antijerk
        logic mult;    // form the filter product
        logic filt;    // update the filter level, which is the output
    } dfpwm_cmd_t;

endpackage

// ===== hdl/dfpwm_bit_if.sv =====
interface dfpwm_bit_if;
    logic valid;
    logic ready;
    logic data_bit;

    modport source (output valid, output data_bit, input ready);
    modport sink   (input valid, input data_bit, output ready);
endinterface

// ===== hdl/dfpwm_sample_if.sv =====
interface dfpwm_sample_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/dfpwm_cfg_if.sv =====
interface dfpwm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dfpwm_pkg::CfgIndexWidth-1:0] index;
    logic [dfpwm_pkg::CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dfpwm_ctrl.sv =====
module dfpwm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dfpwm_pkg::dfpwm_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_MUL  = 4'b0100,
        S_FILT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;
    logic   filt_fire;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_FILT) && slot_free);
    assign accept    = in_valid && in_ready;
    assign filt_fire = (state_reg == S_FILT) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:  state_next = S_MUL;
            S_MUL:  state_next = S_FILT;
            S_FILT:
            begin
                if (slot_free)
                    state_next = accept ? S_UPD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (filt_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.update = (state_reg == S_UPD);
    assign cmd.mult   = (state_reg == S_MUL);
    assign cmd.filt   = filt_fire;

endmodule

// ===== hdl/dfpwm_dp.sv =====
module dfpwm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dfpwm_pkg::dfpwm_cmd_t               cmd,
    input  logic                                data_bit,
    input  logic                                cfg_we,
    input  logic [dfpwm_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [dfpwm_pkg::CfgDataWidth-1:0]  cfg_data,
    output logic signed [7:0]                   sample
);

    // Configuration, stored already clamped to its usable range.
    logic [8:0] coeff_reg, coeff_next;
    logic [9:0] step_reg, step_next;

    // Decoder state.
    logic signed [7:0] charge_reg, charge_next;
    logic [9:0]        strength_reg, strength_next;
    logic              last_high_reg;
    logic signed [7:0] filt_reg, filt_next;

    // Intermediate words.
    logic              high_reg;
    logic signed [19:0] prod1_reg;
    logic signed [7:0]  fin_reg, fin_next;
    logic signed [18:0] prod2_reg;

    logic signed [8:0]  target;
    logic signed [8:0]  diff1;
    logic signed [8:0]  diff2;
    logic signed [19:0] round1;
    logic signed [9:0]  delta;
    logic signed [9:0]  charge_sum;
    logic signed [9:0]  next_wide;
    logic signed [9:0]  avg_sum;
    logic signed [11:0] str_wide;
    logic               flip;
    logic signed [18:0] round2;
    logic signed [10:0] fstep;
    logic signed [10:0] filt_sum;
    logic [8:0]         cfg_coeff_raw;

    // Clamp the register words as they are written.
    assign cfg_coeff_raw = cfg_data[8:0];

    always_comb
    begin
        coeff_next = coeff_reg;
        step_next  = step_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dfpwm_pkg::REG_LPF_COEFF:
                begin
                    if (cfg_coeff_raw == 9'd0)
                        coeff_next = 9'd1;
                    else if (cfg_coeff_raw > dfpwm_pkg::LPF_COEFF_MAX)
                        coeff_next = dfpwm_pkg::LPF_COEFF_MAX;
                    else
                        coeff_next = cfg_coeff_raw;
                end
                dfpwm_pkg::REG_RAMP_STEP:
                begin
                    step_next = (cfg_data == 10'd0) ? 10'd1 : cfg_data;
                end
                default: ;
            endcase
        end
    end

    // Charge product is taken straight from the incoming bit.
    assign target = data_bit ? dfpwm_pkg::LEVEL_HIGH : dfpwm_pkg::LEVEL_LOW;
    assign diff1  = target - 9'(charge_reg);

    // Charge, strength and antijerk update.
    assign round1     = prod1_reg + dfpwm_pkg::CHARGE_ROUND;
    assign delta      = round1[19:10];
    assign charge_sum = 10'(charge_reg) + delta;
    assign flip       = (high_reg != last_high_reg);

    always_comb
    begin
        next_wide = charge_sum;
        if (charge_sum == 10'(charge_reg))
        begin
            if (high_reg && (charge_reg != 8'sd127))
                next_wide = charge_sum + 10'sd1;
            else if (!high_reg && (charge_reg != -8'sd128))
                next_wide = charge_sum - 10'sd1;
        end
    end

    assign charge_next = next_wide[7:0];
    assign avg_sum     = next_wide + 10'(charge_reg) + 10'sd1;
    assign fin_next    = flip ? avg_sum[8:1] : next_wide[7:0];

    always_comb
    begin
        str_wide = $signed({2'b00, strength_reg});
        if (flip)
        begin
            if (strength_reg != 10'd0)
                str_wide = str_wide - $signed({2'b00, step_reg});
        end
        else if (strength_reg != dfpwm_pkg::STRENGTH_TOP)
        begin
            str_wide = str_wide + $signed({2'b00, step_reg});
        end
        if (str_wide < dfpwm_pkg::STRENGTH_MIN)
            str_wide = dfpwm_pkg::STRENGTH_MIN;
        else if (str_wide > dfpwm_pkg::STRENGTH_MAX)
            str_wide = dfpwm_pkg::STRENGTH_MAX;
        strength_next = str_wide[9:0];
    end

    // Low-pass filter.
    assign diff2    = 9'(fin_reg) - 9'(filt_reg);
    assign round2   = prod2_reg + dfpwm_pkg::FILTER_ROUND;
    assign fstep    = round2[18:8];
    assign filt_sum = 11'(filt_reg) + fstep;
    assign filt_next = filt_sum[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg     <= dfpwm_pkg::LPF_COEFF_RESET;
            step_reg      <= dfpwm_pkg::RAMP_STEP_RESET;
            charge_reg    <= 8'sd0;
            strength_reg  <= 10'd0;
            last_high_reg <= 1'b0;
            filt_reg      <= 8'sd0;
        end
        else
        begin
            coeff_reg <= coeff_next;
            step_reg  <= step_next;
            if (cmd.update)
            begin
                charge_reg    <= charge_next;
                strength_reg  <= strength_next;
                last_high_reg <= high_reg;
            end
            if (cmd.filt)
                filt_reg <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            high_reg  <= data_bit;
            prod1_reg <= 20'($signed({1'b0, strength_reg}) * diff1);
        end
        if (cmd.update)
            fin_reg <= fin_next;
        if (cmd.mult)
            prod2_reg <= 19'($signed({1'b0, coeff_reg}) * diff2);
    end

    assign sample = filt_reg;

endmodule

// ===== hdl/dfpwm_bit_decoder.sv =====
// Channel  Role    Payload                      Handshake
// -------  ------  ---------------------------  -----------
// bits     sink    data_bit [0]                 valid/ready
// samples  source  sample [7:0] signed          valid/ready
// cfg      sink    index [7:0], data [9:0]      valid/ready
//
// Each bit word is taken in steps: the charge product is formed on the
// accepting edge, then the charge/strength update, then the filter product;
// the filter add writes the output and may take the next bit on the same
// edge, so a new bit is taken only once the last one reaches the filter add.
// Two multiplies in series, each with its own register, set the spacing of bits.
// A sample waiting on samples.ready holds the filter step; bits wait with it.
// rst_n clears all decoder state at once; cfg is always ready and resets
// lpf_coeff to 140 and ramp_step to 1.
module dfpwm_bit_decoder (
    input  logic        clk,
    input  logic        rst_n,
    dfpwm_bit_if.sink   bits,
    dfpwm_sample_if.source samples,
    dfpwm_cfg_if.sink   cfg
);

    dfpwm_pkg::dfpwm_cmd_t cmd;
    logic                  cfg_we;

    // Take configuration words at any time; software writes only when idle, a rule the block does not enforce.
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // Sequence the load, update, multiply and filter steps.
    dfpwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bits.valid),
        .in_ready  (bits.ready),
        .out_valid (samples.valid),
        .out_ready (samples.ready),
        .cmd       (cmd)
    );

    // Hold the charge, strength, polarity and filter level; the filter
    // level register drives the sample word directly.
    dfpwm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_bit  (bits.data_bit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sample    (samples.sample)
    );

endmodule

// ===== hdl/dfpwm_checker.sv =====
module dfpwm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] sample
);

    // Hold a stalled sample word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("sample word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(sample))
        else $error("sample changed while stalled");

    // Block new bits during the update and multiply steps.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("bit accepted during update");

    // A fresh sample appears only after a bit was taken and passed the update, multiply and filter states.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 4))
        else $error("sample without matching bit");

endmodule

bind dfpwm_bit_decoder dfpwm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bits.valid),
    .in_ready  (bits.ready),
    .out_valid (samples.valid),
    .out_ready (samples.ready),
    .sample    (samples.sample)
);

// ===== bench/dfpwm_bit_decoder_tb.sv =====
`timescale 1ns / 1ps

module dfpwm_bit_decoder_tb;

    // Timing and run shape.
    localparam int HalfPeriod    = 5;
    localparam int ResetCycles   = 12;
    localparam int SettleCycles  = 6;     // settle time after the last owed sample
    localparam int HoldOffCycles = 300;   // long receiver stall, fills the block
    localparam int StallLimit    = 3000;  // cycles with no word moved on any channel
    localparam int RandomPhases  = 11;
    localparam int PhaseWords    = 50;

    // Register indexes outside the map; writes to them must change nothing.
    localparam logic [dfpwm_pkg::CfgIndexWidth-1:0] REG_UNMAPPED_LOW = 8'd2;
    localparam logic [dfpwm_pkg::CfgIndexWidth-1:0] REG_UNMAPPED_TOP = 8'd255;

    typedef enum logic [0:0] {
        ROW_BIT,
        ROW_CFG
    } row_kind_e;

    typedef enum logic [1:0] {
        PAT_RANDOM,
        PAT_RUNS,
        PAT_TOGGLE,
        PAT_BIASED
    } pattern_e;

    typedef struct packed {
        row_kind_e                           kind;
        logic [dfpwm_pkg::CfgIndexWidth-1:0] index;
        logic [dfpwm_pkg::CfgDataWidth-1:0]  data;
        logic                                data_bit;
        logic                                typed;    // sample below is known up front
        logic signed [7:0]                   sample;
    } stim_row_t;

    localparam int DirectedRows = 25;

    // Directed walk: extremes of the bit, coefficient clamps at both ends,
    // the zero ramp step, the full ramp step, and writes to unmapped indexes.
    // Only the very first word after reset has its sample typed in: a zero
    // with zero strength only nudges the charge to -1, and the filter at
    // 140/256 carries that straight through to -1.
    stim_row_t directed_rows [DirectedRows] = '{
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b1, -8'sd1},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_CFG, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_CFG, dfpwm_pkg::REG_LPF_COEFF, 10'd1023, 1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_CFG, dfpwm_pkg::REG_LPF_COEFF, 10'd257,  1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_CFG, dfpwm_pkg::REG_RAMP_STEP, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_CFG, dfpwm_pkg::REG_RAMP_STEP, 10'd1023, 1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b1, 1'b0, 8'sd0},
        '{ROW_CFG, REG_UNMAPPED_LOW,         10'd1,    1'b0, 1'b0, 8'sd0},
        '{ROW_CFG, REG_UNMAPPED_TOP,         10'd1023, 1'b0, 1'b0, 8'sd0},
        '{ROW_BIT, dfpwm_pkg::REG_LPF_COEFF, 10'd0,    1'b0, 1'b0, 8'sd0}
    };

    logic clk;
    logic rst_n;

    dfpwm_bit_if    bits_if ();
    dfpwm_sample_if samples_if ();
    dfpwm_cfg_if    cfg_if ();

    dfpwm_bit_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bits    (bits_if),
        .samples (samples_if),
        .cfg     (cfg_if)
    );

    // Decoder copy: registers and state at the block's widths.
    logic [8:0]        lpf_coeff_reg;
    logic [9:0]        ramp_step_reg;
    logic signed [7:0] charge_lvl;
    logic [9:0]        strength_lvl;
    logic              last_high;
    logic signed [7:0] filtered_lvl;

    // Samples still owed by the block, oldest first.
    logic signed [7:0] pending_samples [$];

    int   error_count  = 0;
    int   stall_cycles = 0;
    bit   hold_request = 1'b0;   // ask the receiver for one long hold-off
    bit   tx_gaps      = 1'b1;   // sender idles between words when set
    bit   typed_armed  = 1'b0;   // next accepted bit carries a typed sample
    logic signed [7:0] typed_sample;

    // Pattern generator state.
    logic run_bit  = 1'b0;
    int   run_left = 0;

    initial clk = 1'b0;
    always #HalfPeriod clk = ~clk;

    task automatic reset_decoder_copy();
        lpf_coeff_reg = dfpwm_pkg::LPF_COEFF_RESET;
        ramp_step_reg = dfpwm_pkg::RAMP_STEP_RESET;
        charge_lvl    = '0;
        strength_lvl  = '0;
        last_high     = 1'b0;
        filtered_lvl  = '0;
    endtask

    // Advance the decoder copy by one bit and return the filtered sample.
    function automatic logic signed [7:0] decode_bit(input logic bit_in);
        int   target;
        int   coeff;
        int   ramp;
        int   chg;
        int   nxt;
        int   goal;
        int   strn;
        int   fin;
        int   filt;
        logic flip;
        target = bit_in ? int'(dfpwm_pkg::LEVEL_HIGH) : int'(dfpwm_pkg::LEVEL_LOW);
        flip   = (bit_in != last_high);
        // Clamp the coefficient to 1..256 and the ramp to at least 1.
        coeff = int'(lpf_coeff_reg);
        if (coeff < 1)
            coeff = 1;
        if (coeff > int'(dfpwm_pkg::LPF_COEFF_MAX))
            coeff = int'(dfpwm_pkg::LPF_COEFF_MAX);
        ramp = int'(ramp_step_reg);
        if (ramp < 1)
            ramp = 1;
        // Move the charge toward the target; nudge it when the move rounds to zero.
        chg = int'(charge_lvl);
        nxt = chg + ((int'(strength_lvl) * (target - chg)
                      + int'(dfpwm_pkg::CHARGE_ROUND)) >>> 10);
        if (nxt == chg && nxt != target)
            nxt += bit_in ? 1 : -1;
        // Ramp the strength up on a repeat, down on a flip, then clamp.
        goal = flip ? 0 : int'(dfpwm_pkg::STRENGTH_MAX);
        strn = int'(strength_lvl);
        if (strn != goal)
            strn += (goal != 0) ? ramp : -ramp;
        if (strn < int'(dfpwm_pkg::STRENGTH_MIN))
            strn = int'(dfpwm_pkg::STRENGTH_MIN);
        if (strn > int'(dfpwm_pkg::STRENGTH_MAX))
            strn = int'(dfpwm_pkg::STRENGTH_MAX);
        // Average old and new charge on a flip, rounding up.
        fin = flip ? ((nxt + chg + 1) >>> 1) : nxt;
        filt = int'(filtered_lvl);
        filt += (coeff * (fin - filt) + int'(dfpwm_pkg::FILTER_ROUND)) >>> 8;
        charge_lvl   = nxt[7:0];
        strength_lvl = strn[9:0];
        last_high    = bit_in;
        filtered_lvl = filt[7:0];
        return filtered_lvl;
    endfunction

    function automatic int pick_tx_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Produce the next bit of a phase: random, long runs, near-alternating,
    // or heavily biased toward one polarity.
    function automatic logic next_pattern_bit(input pattern_e pat);
        case (pat)
            PAT_RUNS:
            begin
                if (run_left == 0)
                begin
                    run_bit  = ~run_bit;
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                return run_bit;
            end
            PAT_TOGGLE:
            begin
                if ($urandom_range(0, 9) != 0)
                    run_bit = ~run_bit;
                return run_bit;
            end
            PAT_BIASED:
            begin
                return ($urandom_range(0, 99) < 85) ? run_bit : ~run_bit;
            end
            default:
            begin
                return 1'($urandom_range(0, 1));
            end
        endcase
    endfunction

    // Offer one bit word and hold it until accepted; then idle at random.
    task automatic send_bit(input logic bit_in);
        int gap;
        bits_if.valid    <= 1'b1;
        bits_if.data_bit <= bit_in;
        do
            @(posedge clk);
        while (!bits_if.ready);
        gap = tx_gaps ? pick_tx_gap() : 0;
        if (gap > 0)
        begin
            bits_if.valid    <= 1'b0;
            bits_if.data_bit <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop the bit channel and wait until every owed sample has come back.
    task automatic wait_idle();
        bits_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dfpwm_pkg::CfgIndexWidth-1:0] index,
                             input logic [dfpwm_pkg::CfgDataWidth-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cfg_if.index <= 8'($urandom_range(0, 255));
        cfg_if.data  <= 10'($urandom_range(0, 1023));
        @(posedge clk);
    endtask

    // Monitor: track register writes, check samples against the oldest
    // owed value, and predict a sample for every accepted bit word.
    always @(posedge clk)
    begin
        logic signed [7:0] want;
        logic signed [7:0] got;
        logic              moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready)
            begin
                moved = 1'b1;
                if (cfg_if.index == dfpwm_pkg::REG_LPF_COEFF)
                    lpf_coeff_reg = cfg_if.data[8:0];
                else if (cfg_if.index == dfpwm_pkg::REG_RAMP_STEP)
                    ramp_step_reg = cfg_if.data;
            end
            if (samples_if.valid && samples_if.ready)
            begin
                moved = 1'b1;
                got   = samples_if.sample;
                if (pending_samples.size() == 0)
                begin
                    $error("sample: none expected, got %0d", got);
                    error_count++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (got !== want)
                    begin
                        $error("sample: expected %0d, got %0d", want, got);
                        error_count++;
                    end
                end
            end
            if (bits_if.valid && bits_if.ready)
            begin
                moved = 1'b1;
                want  = decode_bit(bits_if.data_bit);
                if (typed_armed)
                begin
                    want        = typed_sample;
                    typed_armed = 1'b0;
                end
                pending_samples.push_back(want);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Receiver: alternate ready stretches with short and long holds; on
    // request, hold off for a long stretch so the block backs up.
    initial
    begin
        int stretch;
        int roll;
        samples_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                samples_if.ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    samples_if.ready <= 1'b1;
                    stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                          : $urandom_range(1, 12);
                end
                else
                begin
                    samples_if.ready <= 1'b0;
                    stretch = (roll < 93) ? $urandom_range(1, 3) : $urandom_range(15, 50);
                end
                repeat (stretch) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no word moves for too long.
    initial
    begin
        wait (stall_cycles >= StallLimit);
        $display("** dfpwm_bit_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        pattern_e                           pat;
        logic [dfpwm_pkg::CfgDataWidth-1:0] coeff_word;
        logic [dfpwm_pkg::CfgDataWidth-1:0] ramp_word;

        // Hold every block input at a known value from time zero.
        bits_if.valid    = 1'b0;
        bits_if.data_bit = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        reset_decoder_copy();
        rst_n = 1'b0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; drain before each register write.
        for (int r = 0; r < DirectedRows; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[r].index, directed_rows[r].data);
            end
            else
            begin
                if (directed_rows[r].typed)
                begin
                    typed_sample = directed_rows[r].sample;
                    typed_armed  = 1'b1;
                end
                send_bit(directed_rows[r].data_bit);
            end
        end

        // Random phases: fresh settings each phase, the extremes first, then
        // a mix of in-range and out-of-range words.
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    coeff_word = 10'd1;
                    ramp_word  = 10'd1;
                end
                1:
                begin
                    coeff_word = 10'(dfpwm_pkg::LPF_COEFF_MAX);
                    ramp_word  = 10'(dfpwm_pkg::STRENGTH_TOP);
                end
                2:
                begin
                    coeff_word = 10'd0;
                    ramp_word  = 10'd0;
                end
                default:
                begin
                    coeff_word = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                             : 10'($urandom_range(1, 256));
                    ramp_word  = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                             : 10'($urandom_range(1, 64));
                end
            endcase
            write_reg(dfpwm_pkg::REG_LPF_COEFF, coeff_word);
            write_reg(dfpwm_pkg::REG_RAMP_STEP, ramp_word);

            pat      = pattern_e'(phase % 4);
            run_bit  = 1'($urandom_range(0, 1));
            run_left = 0;
            // Run phases 3 and 8 with words back to back and no sender gaps.
            tx_gaps  = !(phase == 3 || phase == 8);
            // Hold the receiver off while the sender keeps pushing words.
            if (phase == 3)
                hold_request = 1'b1;

            for (int w = 0; w < PhaseWords; w++)
            begin
                // Pause the sender mid-phase until every sample is back.
                if (phase == 6 && w == PhaseWords / 2)
                    wait_idle();
                send_bit(next_pattern_bit(pat));
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("** dfpwm_bit_decoder: PASSED **");
        else
            $display("** dfpwm_bit_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dfpwm_pkg.sv
hdl/dfpwm_bit_if.sv
hdl/dfpwm_sample_if.sv
hdl/dfpwm_cfg_if.sv
hdl/dfpwm_ctrl.sv
hdl/dfpwm_dp.sv
hdl/dfpwm_bit_decoder.sv
hdl/dfpwm_checker.sv
bench/dfpwm_bit_decoder_tb.sv
